FILE: sv/dfl_pkg.sv
package dfl_pkg;

  localparam int unsigned FuncW    = 2;
  localparam int unsigned GateW    = 3;
  localparam int unsigned FaninW   = 3;
  localparam int unsigned NodeW    = 5;
  localparam int unsigned ListW    = 64;
  localparam int unsigned NumLanes = 4;
  localparam int unsigned MaxFanin = 4;

  typedef enum logic [FuncW-1:0] {
    FUNC_ASSIGN = 2'd0,
    FUNC_GATE   = 2'd1,
    FUNC_ACCUM  = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  typedef enum logic [GateW-1:0] {
    GATE_AND  = 3'd0,
    GATE_OR   = 3'd1,
    GATE_NOR  = 3'd2,
    GATE_NAND = 3'd3,
    GATE_INV  = 3'd4,
    GATE_BUF  = 3'd5,
    GATE_XOR  = 3'd6,
    GATE_XNOR = 3'd7
  } gate_e;

  typedef struct packed {
    logic             value;
    logic [ListW-1:0] list;
  } lane_data_t;

  typedef struct packed {
    logic       en;
    lane_data_t data;
  } wr_t;

endpackage

FILE: sv/dfl_if.sv
interface dfl_in_if;
  logic                       valid;
  logic                       ready;
  logic [dfl_pkg::FuncW-1:0]  func;
  logic [dfl_pkg::GateW-1:0]  gate_type;
  logic [dfl_pkg::FaninW-1:0] fanin;
  logic [dfl_pkg::NodeW-1:0]  in_node_0;
  logic [dfl_pkg::NodeW-1:0]  in_node_1;
  logic [dfl_pkg::NodeW-1:0]  in_node_2;
  logic [dfl_pkg::NodeW-1:0]  in_node_3;
  logic [dfl_pkg::NodeW-1:0]  out_node;
  logic                       pin_value;

  modport source (
    output valid, func, gate_type, fanin, in_node_0, in_node_1, in_node_2, in_node_3,
           out_node, pin_value,
    input  ready
  );
  modport sink (
    input  valid, func, gate_type, fanin, in_node_0, in_node_1, in_node_2, in_node_3,
           out_node, pin_value,
    output ready
  );
endinterface

interface dfl_out_if;
  logic                      valid;
  logic                      ready;
  logic                      status;
  logic                      node_value;
  logic [dfl_pkg::ListW-1:0] fault_list;
  logic [dfl_pkg::ListW-1:0] detected_list;

  modport source (
    output valid, status, node_value, fault_list, detected_list,
    input  ready
  );
  modport sink (
    input  valid, status, node_value, fault_list, detected_list,
    output ready
  );
endinterface

FILE: sv/dfl_lane.sv
module dfl_lane #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned IW    = 5
) (
  input  logic                clk_i,
  input  logic                rd_en_i,
  input  logic [IW-1:0]       rd_addr_i,
  input  logic [IW-1:0]       wr_addr_i,
  input  dfl_pkg::wr_t        wr_i,
  output dfl_pkg::lane_data_t rd_o
);

  dfl_pkg::lane_data_t mem [DEPTH];
  dfl_pkg::lane_data_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_addr_i] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_o = rd_q;

endmodule

FILE: sv/dfl_merge.sv
module dfl_merge (
  input  dfl_pkg::gate_e                         gate_i,
  input  logic [dfl_pkg::NumLanes-1:0]           act_i,
  input  dfl_pkg::lane_data_t                    lane_i [dfl_pkg::NumLanes],
  output dfl_pkg::lane_data_t                    res_o
);

  logic                      ctrl;
  logic                      inv;
  logic                      hit;
  logic                      xv;
  logic [dfl_pkg::ListW-1:0] inter;
  logic [dfl_pkg::ListW-1:0] rest;
  logic [dfl_pkg::ListW-1:0] uni;
  logic [dfl_pkg::ListW-1:0] xl;

  always_comb begin
    ctrl  = (gate_i == dfl_pkg::GATE_OR) || (gate_i == dfl_pkg::GATE_NOR);
    inv   = (gate_i == dfl_pkg::GATE_NOR) || (gate_i == dfl_pkg::GATE_NAND);
    inter = '1;
    rest  = '0;
    uni   = '0;
    xl    = '0;
    hit   = 1'b0;
    xv    = (gate_i == dfl_pkg::GATE_XNOR);
    for (int k = 0; k < dfl_pkg::NumLanes; k++) begin
      if (act_i[k]) begin
        uni = uni | lane_i[k].list;
        xl  = xl ^ lane_i[k].list;
        xv  = xv ^ lane_i[k].value;
        if (lane_i[k].value == ctrl) begin
          inter = inter & lane_i[k].list;
          hit   = 1'b1;
        end else begin
          rest = rest | lane_i[k].list;
        end
      end
    end
  end

  always_comb begin
    unique case (gate_i) inside
      dfl_pkg::GATE_INV: begin
        res_o.value = ~lane_i[0].value;
        res_o.list  = lane_i[0].list;
      end
      dfl_pkg::GATE_BUF: begin
        res_o.value = lane_i[0].value;
        res_o.list  = lane_i[0].list;
      end
      dfl_pkg::GATE_XOR, dfl_pkg::GATE_XNOR: begin
        res_o.value = xv;
        res_o.list  = xl;
      end
      default: begin
        if (hit) begin
          res_o.value = ctrl ^ inv;
          res_o.list  = inter & ~rest;
        end else begin
          res_o.value = ~ctrl ^ inv;
          res_o.list  = uni;
        end
      end
    endcase
  end

endmodule

FILE: sv/deductive_fault_list_gate_eval.sv
// Channel  Dir  Carries
// in_i     in   func, gate_type, fanin, in_node_0..3, out_node, pin_value
// out_o    out  status, node_value, fault_list, detected_list
//
// An item is taken in the transfer cycle, which reads one fault-list memory replica per
// gate input into the registered lane read ports; in S_EXEC, once the output register
// is free, the lanes are merged, the list is written back and the result loaded.
// Reset clears known bits, the detected set and handshake state; lists need no clearing.
// A waiting result holds in the output register; the next item is still taken and
// read, and its evaluation holds until the result register frees.
module deductive_fault_list_gate_eval #(
  parameter int unsigned MAX_NODES = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dfl_in_if.sink    in_i,
  dfl_out_if.source out_o
);

  localparam int unsigned IW = $clog2(MAX_NODES);
  localparam int unsigned NL = dfl_pkg::NumLanes;

  typedef enum logic {S_IDLE, S_EXEC} state_e;

  state_e                      state_q, state_d;
  dfl_pkg::func_e              op_q, op_d;
  dfl_pkg::gate_e              gate_q, gate_d;
  logic [NL-1:0]               act_q, act_d;
  logic [IW-1:0]               src_q [NL];
  logic [IW-1:0]               src_d [NL];
  logic [IW-1:0]               dst_q, dst_d;
  logic                        pin_q, pin_d;
  logic [MAX_NODES-1:0]        known_q, known_d;
  logic [dfl_pkg::ListW-1:0]   det_q, det_d;
  logic                        ovalid_q, ovalid_d;
  logic                        ostat_q, ostat_d;
  logic                        oval_q, oval_d;
  logic [dfl_pkg::ListW-1:0]   olist_q, olist_d;

  logic [IW-1:0]               mod_tbl [2**dfl_pkg::NodeW];
  logic [dfl_pkg::NodeW-1:0]   in_raw [NL];
  logic [IW-1:0]               in_src [NL];
  logic [IW-1:0]               in_dst;
  logic [IW-1:0]               rd_addr [NL];
  logic [dfl_pkg::FaninW-1:0]  nsat;
  logic                        accept;
  logic                        exec_fire;
  logic                        unk;
  logic [5:0]                  own_bit;
  dfl_pkg::wr_t                wr;
  dfl_pkg::lane_data_t         lane_rd [NL];
  dfl_pkg::lane_data_t         merged;

  for (genvar k = 0; k < 2**dfl_pkg::NodeW; k++) begin : g_mod
    assign mod_tbl[k] = IW'(k % MAX_NODES);
  end

  assign in_raw[0] = in_i.in_node_0;
  assign in_raw[1] = in_i.in_node_1;
  assign in_raw[2] = in_i.in_node_2;
  assign in_raw[3] = in_i.in_node_3;
  assign in_dst    = mod_tbl[in_i.out_node];

  for (genvar k = 0; k < NL; k++) begin : g_lane
    assign in_src[k] = mod_tbl[in_raw[k]];
    if (k == 0) begin : g_first
      assign rd_addr[k] = (dfl_pkg::func_e'(in_i.func) == dfl_pkg::FUNC_ACCUM) ?
                          in_dst : in_src[k];
    end else begin : g_rest
      assign rd_addr[k] = in_src[k];
    end
    dfl_lane #(.DEPTH(MAX_NODES), .IW(IW)) u_lane (
      .clk_i     (clk_i),
      .rd_en_i   (accept),
      .rd_addr_i (rd_addr[k]),
      .wr_addr_i (dst_q),
      .wr_i      (wr),
      .rd_o      (lane_rd[k])
    );
  end

  dfl_merge u_merge (
    .gate_i (gate_q),
    .act_i  (act_q),
    .lane_i (lane_rd),
    .res_o  (merged)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign exec_fire  = (state_q == S_EXEC) && (!ovalid_q || out_o.ready);

  always_comb begin
    if (in_i.fanin == '0) begin
      nsat = dfl_pkg::FaninW'(1);
    end else if (in_i.fanin > dfl_pkg::FaninW'(dfl_pkg::MaxFanin)) begin
      nsat = dfl_pkg::FaninW'(dfl_pkg::MaxFanin);
    end else begin
      nsat = in_i.fanin;
    end
    if ((dfl_pkg::gate_e'(in_i.gate_type) == dfl_pkg::GATE_INV) ||
        (dfl_pkg::gate_e'(in_i.gate_type) == dfl_pkg::GATE_BUF)) begin
      nsat = dfl_pkg::FaninW'(1);
    end
    for (int k = 0; k < NL; k++) begin
      act_d[k] = dfl_pkg::FaninW'(k) < nsat;
    end
  end

  always_comb begin
    unk = 1'b0;
    for (int k = 0; k < NL; k++) begin
      if (act_q[k] && !known_q[src_q[k]]) begin
        unk = 1'b1;
      end
    end
    if (op_q == dfl_pkg::FUNC_ACCUM) begin
      unk = !known_q[dst_q];
    end
  end

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    gate_d   = gate_q;
    src_d    = src_q;
    dst_d    = dst_q;
    pin_d    = pin_q;
    known_d  = known_q;
    det_d    = det_q;
    ovalid_d = ovalid_q && !out_o.ready;
    ostat_d  = ostat_q;
    oval_d   = oval_q;
    olist_d  = olist_q;
    wr       = '0;
    own_bit  = '0;

    if (accept) begin
      state_d = S_EXEC;
      op_d    = dfl_pkg::func_e'(in_i.func);
      gate_d  = dfl_pkg::gate_e'(in_i.gate_type);
      src_d   = in_src;
      dst_d   = in_dst;
      pin_d   = in_i.pin_value;
    end

    if (exec_fire) begin
      state_d  = S_IDLE;
      ovalid_d = 1'b1;
      ostat_d  = 1'b0;
      oval_d   = 1'b0;
      olist_d  = '0;
      unique case (op_q)
        dfl_pkg::FUNC_ASSIGN: begin
          own_bit        = 6'({dst_q, ~pin_q});
          wr.en          = 1'b1;
          wr.data.value  = pin_q;
          wr.data.list   = dfl_pkg::ListW'(1) << own_bit;
          known_d[dst_q] = 1'b1;
          oval_d         = pin_q;
          olist_d        = wr.data.list;
        end
        dfl_pkg::FUNC_GATE: begin
          if (unk) begin
            ostat_d = 1'b1;
          end else begin
            own_bit        = 6'({dst_q, ~merged.value});
            wr.en          = 1'b1;
            wr.data.value  = merged.value;
            wr.data.list   = merged.list | (dfl_pkg::ListW'(1) << own_bit);
            known_d[dst_q] = 1'b1;
            oval_d         = merged.value;
            olist_d        = wr.data.list;
          end
        end
        dfl_pkg::FUNC_ACCUM: begin
          if (unk) begin
            ostat_d = 1'b1;
          end else begin
            oval_d  = lane_rd[0].value;
            olist_d = lane_rd[0].list;
            det_d   = det_q | lane_rd[0].list;
          end
        end
        default: begin
          known_d = '0;
          det_d   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      known_q  <= '0;
      det_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      known_q  <= known_d;
      det_q    <= det_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    gate_q  <= gate_d;
    src_q   <= src_d;
    dst_q   <= dst_d;
    pin_q   <= pin_d;
    ostat_q <= ostat_d;
    oval_q  <= oval_d;
    olist_q <= olist_d;
    if (accept) begin
      act_q <= act_d;
    end
  end

  assign out_o.valid         = ovalid_q;
  assign out_o.status        = ostat_q;
  assign out_o.node_value    = oval_q;
  assign out_o.fault_list    = olist_q;
  assign out_o.detected_list = det_q;

  a_clear_known : assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_fire && (op_q == dfl_pkg::FUNC_CLEAR) |=> (known_q == '0) && (det_q == '0))
    else $error("clear left known nodes or detected faults");

  a_flag_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_fire && unk && (op_q != dfl_pkg::FUNC_ASSIGN) && (op_q != dfl_pkg::FUNC_CLEAR)
    |=> out_o.status && !out_o.node_value && (out_o.fault_list == '0))
    else $error("flagged result carries data");

  a_det_grow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(exec_fire && (op_q == dfl_pkg::FUNC_CLEAR)) |=> ((det_q & $past(det_q)) == $past(det_q)))
    else $error("detected set lost faults without clear");

  a_exec_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_fire |=> out_o.valid && (state_q == S_IDLE))
    else $error("evaluated item produced no result");

  a_no_wr_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |-> exec_fire && ((op_q == dfl_pkg::FUNC_ASSIGN) || !unk))
    else $error("list write outside evaluation");

endmodule
